FILE: hw/rtl/hook_range_match_table_unit_assert.svh
// Assertion macros used by the hrmt_back table unit module.
`ifndef HOOK_RANGE_MATCH_TABLE_UNIT_ASSERT_SVH
`define HOOK_RANGE_MATCH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define HRMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrmt check failed");

// Next-cycle implication, masked while reset is low.
`define HRMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrmt check failed");

`endif

FILE: hw/rtl/hrmt_pkg.sv
package hrmt_pkg;

  localparam int HANDLE_W = 5;
  localparam int ADDR_W   = 64;
  localparam int KIND_W   = 3;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BLOCK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CODE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RW    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   range_begin;
    logic [ADDR_W-1:0]   range_end;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   address;
    logic                find_on;
    logic                catch_all;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] range_begin;
    logic [ADDR_W-1:0] range_end;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  function automatic logic kind_match(logic [KIND_W-1:0] want, logic [KIND_W-1:0] have);
    logic m;
    m = 1'b0;
    case (want)
      KIND_BLOCK, KIND_CODE: m = (have == want);
      KIND_READ:             m = (have == KIND_READ) || (have == KIND_RW);
      KIND_WRITE:            m = (have == KIND_WRITE) || (have == KIND_RW);
      default:               m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/hook_range_match_table_unit.sv
// Hook range match table.
// Input channel: queue style push/full carrying one command per transaction
// (add, delete or find). Result channel: queue style empty/pop; every
// command yields exactly one result transaction with the handle and the
// four sticky kind flags as they stand after the command.
// A two-entry command queue sits between the input and the table engine,
// and a one-entry result register sits at the output, so the input keeps
// taking commands while a result waits to be popped.
// After a command leaves the queue: a delete, an unused opcode, a suppressed
// find or a find answered by a catch-all finishes in the idle state. An add
// scans the used bits one slot per cycle from slot 1 up to the last slot. A
// find reads the slot memory one slot per cycle through its single read
// port and checks each slot on its registered read data. One command is worked
// at a time, so no new command starts before the last one is done.
// Reset empties both queues, frees all slots and clears catch-alls and
// flags. While the result is not popped, the engine holds and the command
// queue fills; full rises after two waiting commands.
module hook_range_match_table_unit
  import hrmt_pkg::*;
#(
  parameter int TABLE_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [KIND_W-1:0]   in_hook_kind,
  input  logic [ADDR_W-1:0]   in_range_begin,
  input  logic [ADDR_W-1:0]   in_range_end,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic                in_stop_requested,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic                out_any_block,
  output logic                out_any_code,
  output logic                out_any_read,
  output logic                out_any_write
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  hrmt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_opcode         (in_opcode),
    .in_hook_kind      (in_hook_kind),
    .in_range_begin    (in_range_begin),
    .in_range_end      (in_range_end),
    .in_handle         (in_handle),
    .in_address        (in_address),
    .in_stop_requested (in_stop_requested),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop)
  );

  hrmt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_result_handle (out_result_handle),
    .out_any_block     (out_any_block),
    .out_any_code      (out_any_code),
    .out_any_read      (out_any_read),
    .out_any_write     (out_any_write)
  );

endmodule

FILE: hw/rtl/hrmt_ram.sv
module hrmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/hrmt_front.sv
module hrmt_front
  import hrmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [KIND_W-1:0]   in_hook_kind,
  input  logic [ADDR_W-1:0]   in_range_begin,
  input  logic [ADDR_W-1:0]   in_range_end,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic                in_stop_requested,
  output logic                q_valid,
  output cmd_t                q_cmd,
  input  logic                q_pop
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_in;
  logic       push_ok, pop_ok;

  always_comb begin
    cmd_in.opcode      = in_opcode;
    cmd_in.kind        = in_hook_kind;
    cmd_in.range_begin = in_range_begin;
    cmd_in.range_end   = in_range_end;
    cmd_in.handle      = in_handle;
    cmd_in.address     = in_address;
    cmd_in.find_on     = (in_opcode == OP_FIND) && !in_stop_requested;
    cmd_in.catch_all   = in_range_begin > in_range_end;
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= !wr_ptr_r;
      if (pop_ok)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

FILE: hw/rtl/hrmt_back.sv
`include "hook_range_match_table_unit_assert.svh"

module hrmt_back
  import hrmt_pkg::*;
#(
  parameter int TABLE_SLOTS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic                out_any_block,
  output logic                out_any_code,
  output logic                out_any_read,
  output logic                out_any_write
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);
  localparam logic [IW-1:0] FIRST = IW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]             st_r, st_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [IW-1:0]          pend_idx_r, pend_idx_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [TABLE_SLOTS-1:0] used_r, used_nxt;
  logic [HANDLE_W-1:0]    ca_blk_r, ca_blk_nxt, ca_code_r, ca_code_nxt;
  logic [HANDLE_W-1:0]    ca_rd_r, ca_rd_nxt, ca_wr_r, ca_wr_nxt;
  logic [3:0]             flags_r, flags_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [HANDLE_W-1:0]    out_h_r, out_h_nxt;
  logic [3:0]             out_f_r, out_f_nxt;

  logic                   we;
  slot_t                  wdata, rdata;
  logic                   start, fin;
  logic [HANDLE_W-1:0]    res, ca_sel;
  logic                   hit;

  hrmt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign wdata = '{kind: cmd_r.kind, range_begin: cmd_r.range_begin,
                   range_end: cmd_r.range_end};
  assign start = (st_r == S_IDLE) && q_valid && (!out_v_r || out_pop);
  assign q_pop = start;
  assign hit   = used_r[pend_idx_r] && kind_match(cmd_r.kind, rdata.kind) &&
                 (rdata.range_begin <= cmd_r.address) &&
                 (cmd_r.address <= rdata.range_end);

  always_comb begin
    case (q_cmd.kind)
      KIND_BLOCK: ca_sel = ca_blk_r;
      KIND_CODE:  ca_sel = ca_code_r;
      KIND_READ:  ca_sel = ca_rd_r;
      KIND_WRITE: ca_sel = ca_wr_r;
      default:    ca_sel = '0;
    endcase
  end

  always_comb begin
    st_nxt       = st_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    cmd_nxt      = cmd_r;
    used_nxt     = used_r;
    ca_blk_nxt   = ca_blk_r;
    ca_code_nxt  = ca_code_r;
    ca_rd_nxt    = ca_rd_r;
    ca_wr_nxt    = ca_wr_r;
    flags_nxt    = flags_r;
    we           = 1'b0;
    fin          = 1'b0;
    res          = '0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = q_cmd;
          unique case (q_cmd.opcode)
            OP_ADD: begin
              idx_nxt = FIRST;
              st_nxt  = S_ADD;
            end
            OP_DEL: begin
              fin = 1'b1;
              if ((q_cmd.handle != '0) && (int'(q_cmd.handle) < TABLE_SLOTS)) begin
                if (ca_blk_r == q_cmd.handle)  ca_blk_nxt  = '0;
                if (ca_code_r == q_cmd.handle) ca_code_nxt = '0;
                if (ca_rd_r == q_cmd.handle)   ca_rd_nxt   = '0;
                if (ca_wr_r == q_cmd.handle)   ca_wr_nxt   = '0;
                used_nxt[IW'(q_cmd.handle)] = 1'b0;
              end
            end
            OP_FIND: begin
              if (!q_cmd.find_on || !kind_match(q_cmd.kind, q_cmd.kind)) begin
                fin = 1'b1;
              end else if (ca_sel != '0) begin
                fin = 1'b1;
                res = ca_sel;
              end else begin
                idx_nxt    = FIRST;
                pend_v_nxt = 1'b0;
                st_nxt     = S_FIND;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_ADD: begin
        if (!used_r[idx_r]) begin
          we              = 1'b1;
          used_nxt[idx_r] = 1'b1;
          fin             = 1'b1;
          res             = HANDLE_W'(idx_r);
          st_nxt          = S_IDLE;
          case (cmd_r.kind)
            KIND_BLOCK: begin
              flags_nxt[0] = 1'b1;
              if (cmd_r.catch_all) ca_blk_nxt = HANDLE_W'(idx_r);
            end
            KIND_CODE: begin
              flags_nxt[1] = 1'b1;
              if (cmd_r.catch_all) ca_code_nxt = HANDLE_W'(idx_r);
            end
            KIND_READ: begin
              flags_nxt[2] = 1'b1;
              if (cmd_r.catch_all) ca_rd_nxt = HANDLE_W'(idx_r);
            end
            KIND_WRITE: begin
              flags_nxt[3] = 1'b1;
              if (cmd_r.catch_all) ca_wr_nxt = HANDLE_W'(idx_r);
            end
            KIND_RW: begin
              flags_nxt[3:2] = 2'b11;
              if (cmd_r.catch_all) begin
                ca_rd_nxt = HANDLE_W'(idx_r);
                ca_wr_nxt = HANDLE_W'(idx_r);
              end
            end
            default: ;
          endcase
        end else if (idx_r == LAST) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + FIRST;
        end
      end
      S_FIND: begin
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = idx_r;
        if (idx_r != LAST) idx_nxt = idx_r + FIRST;
        if (pend_v_r && hit) begin
          fin    = 1'b1;
          res    = HANDLE_W'(pend_idx_r);
          st_nxt = S_IDLE;
        end else if (pend_v_r && (pend_idx_r == LAST)) begin
          fin    = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r && !out_pop;
    out_h_nxt = out_h_r;
    out_f_nxt = out_f_r;
    if (fin) begin
      out_v_nxt = 1'b1;
      out_h_nxt = res;
      out_f_nxt = flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_h_r    <= out_h_nxt;
    out_f_r    <= out_f_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      idx_r     <= FIRST;
      pend_v_r  <= 1'b0;
      used_r    <= '0;
      ca_blk_r  <= '0;
      ca_code_r <= '0;
      ca_rd_r   <= '0;
      ca_wr_r   <= '0;
      flags_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      idx_r     <= idx_nxt;
      pend_v_r  <= pend_v_nxt;
      used_r    <= used_nxt;
      ca_blk_r  <= ca_blk_nxt;
      ca_code_r <= ca_code_nxt;
      ca_rd_r   <= ca_rd_nxt;
      ca_wr_r   <= ca_wr_nxt;
      flags_r   <= flags_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  assign out_empty         = !out_v_r;
  assign out_result_handle = out_h_r;
  assign out_any_block     = out_f_r[0];
  assign out_any_code      = out_f_r[1];
  assign out_any_read      = out_f_r[2];
  assign out_any_write     = out_f_r[3];

  `HRMT_ASSERT_IMP(a_scan_no_result, clk, rst_n, st_r != S_IDLE, !out_v_r)
  `HRMT_ASSERT_IMP(a_slot0_free, clk, rst_n, 1'b1, !used_r[0])
  `HRMT_ASSERT_IMP(a_scan_idx, clk, rst_n, st_r == S_ADD, idx_r != '0)
  `HRMT_ASSERT_NXT(a_flags_sticky, clk, rst_n, flags_r != 4'd0, flags_r != 4'd0)

endmodule
